// ===== rtl/i2cdw_pkg.sv =====
// Types and constants for the I2C display write master.
// Used by i2c_display_write_master; no dependencies.
`default_nettype none

package i2cdw_pkg;

  // Input item: one bus tick
  typedef struct packed {
    logic       start_req;
    logic [7:0] byte_value;
    logic       is_data;
    logic       sda_in;
  } in_t;

  // Result item: line levels and status for one tick
  typedef struct packed {
    logic scl;
    logic sda_out;
    logic sda_drive;
    logic busy_res;
    logic done_res;
    logic nack;
  } out_t;

  // Bus phases, one-hot
  typedef enum logic [12:0] {
    PH_IDLE = 13'b0_0000_0000_0001,
    PH_ST0  = 13'b0_0000_0000_0010,
    PH_ST1  = 13'b0_0000_0000_0100,
    PH_ST2  = 13'b0_0000_0000_1000,
    PH_BT0  = 13'b0_0000_0001_0000,
    PH_BT1  = 13'b0_0000_0010_0000,
    PH_BT2  = 13'b0_0000_0100_0000,
    PH_AK0  = 13'b0_0000_1000_0000,
    PH_AK1  = 13'b0_0001_0000_0000,
    PH_AK2  = 13'b0_0010_0000_0000,
    PH_SP0  = 13'b0_0100_0000_0000,
    PH_SP1  = 13'b0_1000_0000_0000,
    PH_SP2  = 13'b1_0000_0000_0000
  } phase_t;

  // Register map (index = paddr[2])
  localparam logic REG_DEVICE_ADDRESS = 1'b0;
  localparam logic REG_PHASE_TICKS    = 1'b1;

  localparam logic [7:0]  DEVICE_ADDRESS_RESET = 8'h78;
  localparam logic [15:0] PHASE_TICKS_RESET    = 16'd1;

  localparam logic [7:0] CTRL_COMMAND = 8'h00;
  localparam logic [7:0] CTRL_DATA    = 8'h40;

  localparam logic [1:0] LAST_BYTE = 2'd2;
  localparam logic [2:0] LAST_BIT  = 3'd7;

endpackage

`default_nettype wire

// ===== rtl/i2c_display_write_master.sv =====
// I2C display write master: top level, phase sequencer and APB register file.
// Depends on i2cdw_pkg.
`default_nettype none
//
// Usage
//   The input channel carries one item per bus tick (in_valid/in_stall/in_data).
//   An item with start_req set while idle latches byte_value and is_data and
//   starts a transfer: start condition, address byte (device_address), control
//   byte (0x00 command / 0x40 data), payload byte, stop. Each bit and ack slot
//   is three phases of phase_ticks ticks each (0 counts as 1). sda_in is
//   sampled on the last tick of the middle ack phase; a NACK goes straight to
//   the stop condition and is flagged with done_res on the finishing tick.
//   The result channel returns one item per input item (line levels, busy,
//   done, nack), in the cycle after acceptance, from a single output register.
//   Throughput: one item per cycle while the receiver does not stall; the
//   sequencer state and the output register both update at every accepted item.
//   When the receiver stalls, the output register holds and in_stall rises
//   for as long as the held result is not taken; no items are lost.
//   Reset (rst_n low, synchronous): idle, registers at device_address 0x78
//   and phase_ticks 1, no result pending.
//   Configuration: APB, pready tied high, registers at byte 0 and 4; write only
//   while idle.

module i2c_display_write_master
  import i2cdw_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  // input channel
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire in_t         in_data,
  // result channel
  output logic             out_valid,
  input  wire logic        out_stall,
  output out_t             out_data,
  // configuration
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  // ---------------- configuration registers ----------------
  logic [7:0]  dev_addr_r;
  logic [15:0] phase_ticks_r;
  logic        cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dev_addr_r    <= DEVICE_ADDRESS_RESET;
      phase_ticks_r <= PHASE_TICKS_RESET;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        REG_DEVICE_ADDRESS: dev_addr_r    <= pwdata[7:0];
        REG_PHASE_TICKS:    phase_ticks_r <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_DEVICE_ADDRESS: prdata = {24'd0, dev_addr_r};
      REG_PHASE_TICKS:    prdata = {16'd0, phase_ticks_r};
      default:            prdata = 32'd0;
    endcase
  end

  // ---------------- sequencer state ----------------
  phase_t      state_r, state_nxt;
  logic [1:0]  byte_idx_r, byte_idx_nxt;
  logic [2:0]  bit_idx_r, bit_idx_nxt;
  logic [15:0] tick_r, tick_nxt;
  logic [7:0]  shift_r, shift_nxt;
  logic [7:0]  payload_r, payload_nxt;
  logic        kind_r, kind_nxt;
  logic        nack_seen_r, nack_seen_nxt;

  logic        out_valid_r;
  out_t        out_data_r, res_nxt;
  logic        in_accept;

  // A new item enters whenever the output register is empty or drains now.
  assign in_stall  = out_valid_r & out_stall;
  assign in_accept = in_valid & ~in_stall;

  always_comb begin
    phase_t      cur_state;
    logic [1:0]  cur_byte;
    logic [2:0]  cur_bit;
    logic [15:0] cur_tick;
    logic [7:0]  cur_shift;
    logic        cur_nack;
    logic [15:0] lim;
    logic [16:0] cnt;
    logic        b;

    cur_state   = state_r;
    cur_byte    = byte_idx_r;
    cur_bit     = bit_idx_r;
    cur_tick    = tick_r;
    cur_shift   = shift_r;
    cur_nack    = nack_seen_r;
    payload_nxt = payload_r;
    kind_nxt    = kind_r;

    // request taken only when idle; its tick is already the first start tick
    if ((state_r == PH_IDLE) && in_data.start_req) begin
      payload_nxt = in_data.byte_value;
      kind_nxt    = in_data.is_data;
      cur_shift   = dev_addr_r;
      cur_byte    = 2'd0;
      cur_bit     = 3'd0;
      cur_tick    = 16'd0;
      cur_nack    = 1'b0;
      cur_state   = PH_ST0;
    end

    state_nxt     = cur_state;
    byte_idx_nxt  = cur_byte;
    bit_idx_nxt   = cur_bit;
    tick_nxt      = cur_tick;
    shift_nxt     = cur_shift;
    nack_seen_nxt = cur_nack;

    b   = cur_shift[LAST_BIT - cur_bit];
    lim = (phase_ticks_r == 16'd0) ? 16'd1 : phase_ticks_r;
    cnt = {1'b0, cur_tick} + 17'd1;

    res_nxt = '{scl: 1'b1, sda_out: 1'b1, sda_drive: 1'b1,
                busy_res: 1'b0, done_res: 1'b0, nack: 1'b0};

    // line levels of the current phase (idle holds all high and driven)
    unique case (cur_state)
      PH_ST1:                 {res_nxt.scl, res_nxt.sda_out} = 2'b10;
      PH_ST2, PH_SP0:         {res_nxt.scl, res_nxt.sda_out} = 2'b00;
      PH_BT0, PH_BT2:         {res_nxt.scl, res_nxt.sda_out} = {1'b0, b};
      PH_BT1:                 {res_nxt.scl, res_nxt.sda_out} = {1'b1, b};
      PH_AK0, PH_AK2:         {res_nxt.scl, res_nxt.sda_out, res_nxt.sda_drive} = 3'b000;
      PH_AK1:                 {res_nxt.scl, res_nxt.sda_out, res_nxt.sda_drive} = 3'b100;
      PH_SP1:                 {res_nxt.scl, res_nxt.sda_out} = 2'b10;
      default: ;              // idle, ST0, SP2: all high
    endcase

    if (cur_state != PH_IDLE) begin
      res_nxt.busy_res = 1'b1;
      if (cnt < {1'b0, lim}) begin
        tick_nxt = cnt[15:0];
      end else begin
        tick_nxt = 16'd0;
        unique case (cur_state)
          PH_ST0: state_nxt = PH_ST1;
          PH_ST1: state_nxt = PH_ST2;
          PH_ST2: state_nxt = PH_BT0;
          PH_BT0: state_nxt = PH_BT1;
          PH_BT1: state_nxt = PH_BT2;
          PH_BT2: begin
            if (cur_bit == LAST_BIT) begin
              bit_idx_nxt = 3'd0;
              state_nxt   = PH_AK0;
            end else begin
              bit_idx_nxt = cur_bit + 3'd1;
              state_nxt   = PH_BT0;
            end
          end
          PH_AK0: state_nxt = PH_AK1;
          PH_AK1: begin
            if (in_data.sda_in) begin
              nack_seen_nxt = 1'b1;
              state_nxt     = PH_SP0;
            end else begin
              state_nxt = PH_AK2;
            end
          end
          PH_AK2: begin
            if (cur_byte >= LAST_BYTE) begin
              state_nxt = PH_SP0;
            end else begin
              byte_idx_nxt = cur_byte + 2'd1;
              // address done -> control byte; control done -> payload
              if (cur_byte == 2'd0) begin
                shift_nxt = kind_nxt ? CTRL_DATA : CTRL_COMMAND;
              end else begin
                shift_nxt = payload_nxt;
              end
              bit_idx_nxt = 3'd0;
              state_nxt   = PH_BT0;
            end
          end
          PH_SP0: state_nxt = PH_SP1;
          PH_SP1: state_nxt = PH_SP2;
          PH_SP2: begin
            res_nxt.done_res = 1'b1;
            res_nxt.nack     = cur_nack;
            state_nxt        = PH_IDLE;
          end
          default: state_nxt = PH_IDLE;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= PH_IDLE;
      byte_idx_r  <= 2'd0;
      bit_idx_r   <= 3'd0;
      tick_r      <= 16'd0;
      shift_r     <= 8'd0;
      payload_r   <= 8'd0;
      kind_r      <= 1'b0;
      nack_seen_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_accept) begin
        state_r     <= state_nxt;
        byte_idx_r  <= byte_idx_nxt;
        bit_idx_r   <= bit_idx_nxt;
        tick_r      <= tick_nxt;
        shift_r     <= shift_nxt;
        payload_r   <= payload_nxt;
        kind_r      <= kind_nxt;
        nack_seen_r <= nack_seen_nxt;
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // result payload register, no reset needed
  always_ff @(posedge clk) begin
    if (in_accept) begin
      out_data_r <= res_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // ---------------- assertions ----------------
  a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.done_res) |-> out_data_r.busy_res)
    else $error("done without busy");

  a_nack_done: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.nack) |-> out_data_r.done_res)
    else $error("nack outside finishing tick");

  a_idle_lines: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_data_r.busy_res) |->
      (out_data_r.scl && out_data_r.sda_out && out_data_r.sda_drive))
    else $error("lines not driven high while idle");

  a_accept_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept |=> out_valid_r)
    else $error("accepted tick produced no result");

  a_done_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (in_accept && res_nxt.done_res) |=> (state_r == PH_IDLE))
    else $error("sequencer not idle after finishing tick");

endmodule

`default_nettype wire

// ===== dv/i2c_display_write_master_tb.sv =====
// Self-checking testbench for i2c_display_write_master: bus tick sequencing,
// ack/nack handling and the APB registers, checked against a cycle model.
// Depends on i2cdw_pkg and the i2c_display_write_master RTL.

module i2c_display_write_master_tb;
  import i2cdw_pkg::*;

  localparam int CYCLE_LIMIT = 600000;
  localparam int NO_NACK     = 3;    // byte number that never occurs: all bytes acked

  logic        clk;
  logic        rst_n     = 1'b0;
  logic        in_valid  = 1'b0;
  logic        in_stall;
  in_t         in_data   = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_t        out_data;
  logic        psel      = 1'b0;
  logic        penable   = 1'b0;
  logic        pwrite    = 1'b0;
  logic [2:0]  paddr     = '0;
  logic [31:0] pwdata    = '0;
  logic [31:0] prdata;
  logic        pready;

  i2c_display_write_master u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  // Register copies as last written over APB
  logic [7:0]  dev_addr    = DEVICE_ADDRESS_RESET;
  logic [15:0] phase_ticks = PHASE_TICKS_RESET;

  // Sequencer copy
  phase_t      bus_phase = PH_IDLE;
  logic [1:0]  byte_idx  = '0;
  logic [2:0]  bit_idx   = '0;
  logic [15:0] tick_cnt  = '0;
  logic [7:0]  shifter   = '0;
  logic [7:0]  payload   = '0;
  logic        kind      = 1'b0;
  logic        held_scl  = 1'b1;
  logic        held_sda  = 1'b1;
  logic        held_drv  = 1'b1;
  logic        nack_flag = 1'b0;

  out_t tick_results[$];   // expected line levels/status, oldest first
  int   errors      = 0;
  int   cycles      = 0;
  int   gap_max     = 0;   // 0: sender never pauses
  int   stall_pct   = 0;   // 0: receiver never stalls
  int   burst_left  = 0;
  int   stall_left  = 0;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // One bus tick: advance the sequencer copy, return the levels it drives.
  function automatic out_t bus_tick(input in_t it);
    out_t        r;
    logic        bitv;
    logic [16:0] lim;
    logic [16:0] cnt;
    r = '0;
    if (bus_phase == PH_IDLE && it.start_req) begin
      payload   = it.byte_value;
      kind      = it.is_data;
      shifter   = dev_addr;
      byte_idx  = '0;
      bit_idx   = '0;
      tick_cnt  = '0;
      nack_flag = 1'b0;
      bus_phase = PH_ST0;
    end
    if (bus_phase != PH_IDLE) begin
      r.busy_res = 1'b1;
      bitv = shifter[LAST_BIT - bit_idx];
      case (bus_phase)
        PH_ST0:  {held_scl, held_sda, held_drv} = 3'b111;
        PH_ST1:  {held_scl, held_sda, held_drv} = 3'b101;
        PH_ST2:  {held_scl, held_sda, held_drv} = 3'b001;
        PH_BT0:  {held_scl, held_sda, held_drv} = {1'b0, bitv, 1'b1};
        PH_BT1:  {held_scl, held_sda, held_drv} = {1'b1, bitv, 1'b1};
        PH_BT2:  {held_scl, held_sda, held_drv} = {1'b0, bitv, 1'b1};
        PH_AK0:  {held_scl, held_sda, held_drv} = 3'b000;
        PH_AK1:  {held_scl, held_sda, held_drv} = 3'b100;
        PH_AK2:  {held_scl, held_sda, held_drv} = 3'b000;
        PH_SP0:  {held_scl, held_sda, held_drv} = 3'b001;
        PH_SP1:  {held_scl, held_sda, held_drv} = 3'b101;
        default: {held_scl, held_sda, held_drv} = 3'b111;
      endcase
      // zero ticks per phase behaves as one
      lim = (phase_ticks == '0) ? 17'd1 : {1'b0, phase_ticks};
      cnt = {1'b0, tick_cnt} + 17'd1;
      if (cnt < lim) begin
        tick_cnt = cnt[15:0];
      end else begin
        tick_cnt = '0;
        case (bus_phase)
          PH_ST0: bus_phase = PH_ST1;
          PH_ST1: bus_phase = PH_ST2;
          PH_ST2: bus_phase = PH_BT0;
          PH_BT0: bus_phase = PH_BT1;
          PH_BT1: bus_phase = PH_BT2;
          PH_BT2: begin
            if (bit_idx == LAST_BIT) begin
              bit_idx   = '0;
              bus_phase = PH_AK0;
            end else begin
              bit_idx   = bit_idx + 3'd1;
              bus_phase = PH_BT0;
            end
          end
          PH_AK0: bus_phase = PH_AK1;
          PH_AK1: begin
            if (it.sda_in) begin
              nack_flag = 1'b1;
              bus_phase = PH_SP0;
            end else begin
              bus_phase = PH_AK2;
            end
          end
          PH_AK2: begin
            if (byte_idx >= LAST_BYTE) begin
              bus_phase = PH_SP0;
            end else begin
              byte_idx  = byte_idx + 2'd1;
              shifter   = (byte_idx == 2'd1) ? (kind ? CTRL_DATA : CTRL_COMMAND) : payload;
              bit_idx   = '0;
              bus_phase = PH_BT0;
            end
          end
          PH_SP0: bus_phase = PH_SP1;
          PH_SP1: bus_phase = PH_SP2;
          PH_SP2: begin
            r.done_res = 1'b1;
            r.nack     = nack_flag;
            bus_phase  = PH_IDLE;
          end
          default: bus_phase = PH_IDLE;
        endcase
      end
    end
    r.scl       = held_scl;
    r.sda_out   = held_sda;
    r.sda_drive = held_drv;
    return r;
  endfunction

  function automatic void check_bit(input string what, input logic want, input logic got);
    if (got !== want) begin
      errors++;
      $display("%0t: %s expected %0b actual %0b", $time, what, want, got);
    end
  endfunction

  // Result checker: every taken result against the oldest expectation
  always @(posedge clk) begin : check_results
    out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (tick_results.size() == 0) begin
        errors++;
        $display("%0t: result expected none actual %b", $time, out_data);
      end else begin
        want = tick_results.pop_front();
        check_bit("scl", want.scl, out_data.scl);
        check_bit("sda_out", want.sda_out, out_data.sda_out);
        check_bit("sda_drive", want.sda_drive, out_data.sda_drive);
        check_bit("busy_res", want.busy_res, out_data.busy_res);
        check_bit("done_res", want.done_res, out_data.done_res);
        check_bit("nack", want.nack, out_data.nack);
      end
    end
  end

  // Receiver stalls at random, in runs, when stall_pct is set
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else if (stall_pct > 0 && $urandom_range(0, 99) < stall_pct) begin
      stall_left = $urandom_range(0, 7);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("i2c_display_write_master_tb: FAIL");
      $finish;
    end
  end

  // One tick item; sender pauses between bursts when gap_max is set
  task automatic send_tick(input logic req, input logic [7:0] b, input logic k,
                           input logic sda);
    in_t it;
    it.start_req  = req;
    it.byte_value = b;
    it.is_data    = k;
    it.sda_in     = sda;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      if (gap_max > 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, gap_max)) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (in_stall);
    tick_results.push_back(bus_tick(it));
  endtask

  task automatic send_quiet_ticks(input int n);
    repeat (n) send_tick(1'b0, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b0);
  endtask

  // Run the current transfer to its stop; NACK the byte numbered nack_at
  task automatic finish_transfer(input int nack_at, input logic hold_req);
    while (bus_phase != PH_IDLE)
      send_tick(hold_req, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                byte_idx == nack_at);
  endtask

  task automatic run_transfer(input logic [7:0] b, input logic k, input int nack_at,
                              input logic hold_req);
    send_tick(1'b1, b, k, 1'b0);
    finish_transfer(nack_at, hold_req);
  endtask

  task automatic wait_quiet();
    in_valid <= 1'b0;
    burst_left = 0;
    while (tick_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // APB write then read back; only with the channel drained
  task automatic cfg_write(input logic idx, input logic [31:0] val);
    logic [31:0] mask;
    logic [31:0] got;
    wait_quiet();
    mask = (idx == REG_DEVICE_ADDRESS) ? 32'h0000_00FF : 32'h0000_FFFF;
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (idx == REG_DEVICE_ADDRESS) dev_addr = val[7:0];
    else phase_ticks = val[15:0];
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    got = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    if ((got & mask) !== (val & mask)) begin
      errors++;
      $display("%0t: register %0d read expected %h actual %h", $time, idx, val & mask,
               got & mask);
    end
    @(posedge clk);
  endtask

  task automatic test_idle_after_reset();
    repeat (6) send_tick(1'b0, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                         1'($urandom_range(0, 1)));
  endtask

  // Reset address; request held through the whole transfer and its last tick
  task automatic test_command_write();
    run_transfer(8'hFF, 1'b0, NO_NACK, 1'b1);
    run_transfer(8'h00, 1'b1, NO_NACK, 1'b0);
  endtask

  task automatic test_nack_each_byte();
    cfg_write(REG_DEVICE_ADDRESS, 32'h00);
    run_transfer(8'hA5, 1'b1, 0, 1'b0);
    cfg_write(REG_DEVICE_ADDRESS, 32'hFF);
    run_transfer(8'h5A, 1'b0, 1, 1'b0);
    run_transfer(8'h81, 1'b1, 2, 1'b0);
  endtask

  // Zero and maximum phase length, and changes in the middle of a phase
  task automatic test_phase_ticks();
    gap_max   = 3;
    stall_pct = 30;
    cfg_write(REG_PHASE_TICKS, 32'd0);
    run_transfer(8'h3C, 1'b1, NO_NACK, 1'b0);
    cfg_write(REG_PHASE_TICKS, 32'd65535);
    send_tick(1'b1, 8'hC3, 1'b0, 1'b0);
    send_quiet_ticks(150);
    cfg_write(REG_PHASE_TICKS, 32'd1);
    send_quiet_ticks(40);
    cfg_write(REG_PHASE_TICKS, 32'd6);
    send_quiet_ticks(3);
    cfg_write(REG_PHASE_TICKS, 32'd2);
    finish_transfer(NO_NACK, 1'b0);
    cfg_write(REG_DEVICE_ADDRESS, {24'd0, DEVICE_ADDRESS_RESET});
    cfg_write(REG_PHASE_TICKS, {16'd0, PHASE_TICKS_RESET});
  endtask

  // Segments of random traffic, each under its own settings and idling;
  // each ends with the transfer in flight run to its stop
  task automatic test_random_traffic(input int target);
    int sent;
    int seg;
    int r;
    sent = 0;
    while (sent < target) begin
      r = $urandom_range(0, 9);
      cfg_write(REG_DEVICE_ADDRESS, $urandom_range(0, 255));
      cfg_write(REG_PHASE_TICKS, (r == 0) ? 0 : (r < 6) ? 1 : (r < 8) ? 2 :
                                 (r == 8) ? 3 : $urandom_range(4, 8));
      gap_max   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      stall_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(5, 40);
      seg = $urandom_range(60, 250);
      repeat (seg)
        send_tick($urandom_range(0, 99) < 30, 8'($urandom_range(0, 255)),
                  1'($urandom_range(0, 1)), $urandom_range(0, 99) < 8);
      sent += seg;
      while (bus_phase != PH_IDLE) begin
        send_tick($urandom_range(0, 99) < 30, 8'($urandom_range(0, 255)),
                  1'($urandom_range(0, 1)), $urandom_range(0, 99) < 8);
        sent++;
      end
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_idle_after_reset();
    test_command_write();
    test_nack_each_byte();
    test_phase_ticks();
    test_random_traffic(560);
    wait_quiet();
    repeat (10) @(posedge clk);
    if (errors == 0) begin
      $display("i2c_display_write_master_tb: PASS");
    end else begin
      $display("i2c_display_write_master_tb: FAIL");
    end
    $finish;
  end

endmodule

// ===== i2c_display_write_master.f =====
rtl/i2cdw_pkg.sv
rtl/i2c_display_write_master.sv
dv/i2c_display_write_master_tb.sv
